/* rtl/mlet_pkg.sv */
// ----------------------------------------------------------------------------
// mlet_pkg
// Types and constants for the motor link, encoder and telemetry front end.
// ----------------------------------------------------------------------------
package mlet_pkg;

    localparam logic [7:0] CLOSED_HDR_RESET    = 8'd0;
    localparam logic [7:0] DIRECT_HDR_RESET    = 8'd1;
    localparam logic [7:0] SILENCE_LIMIT_RESET = 8'd60;
    localparam logic [7:0] SILENCE_COUNT_RESET = 8'd100;

    typedef enum logic [2:0] {
        REQ_LINK  = 3'd0,
        REQ_ENC   = 3'd1,
        REQ_TICK  = 3'd2,
        REQ_ADC   = 3'd3,
        REQ_DRIVE = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        RX_HEADER   = 3'd0,
        RX_SETPOINT = 3'd1,
        RX_VOLTAGE  = 3'd2,
        RX_DRIVE    = 3'd3,
        RX_TAIL     = 3'd4
    } t_rx_phase;

    typedef enum logic [1:0] {
        CFG_CLOSED_HDR    = 2'd0,
        CFG_DIRECT_HDR    = 2'd1,
        CFG_SILENCE_LIMIT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [7:0]        link_byte;
        logic              chan_a;
        logic              chan_b;
        logic [7:0]        adc_value;
        logic signed [7:0] applied_drive;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         reply_byte;
        logic signed [7:0]  setpoint_now;
        logic               mode_now;
        logic signed [15:0] velocity_now;
        logic               update_due;
        logic               timed_out;
        logic [7:0]         host_voltage;
    } t_out_item;

endpackage

/* rtl/motor_link_encoder_telemetry.sv */
// ----------------------------------------------------------------------------
// motor_link_encoder_telemetry
// Motor board front end: serial packet receiver, quadrature count, tick
// velocity latch with setpoint timeout, ADC sample store and drive store.
// ----------------------------------------------------------------------------
// Every accepted transaction yields exactly one result transaction, carrying
// the block state after the event. A transaction is registered on input and
// its result in the result register; one transaction is taken every clock
// unless the output stalls, with the two registers separating the handshakes.
// The state update is one combinational pass: one per cycle when not stalled.
module motor_link_encoder_telemetry (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mlet_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mlet_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import mlet_pkg::*;

    logic [7:0] r_closed_hdr, r_direct_hdr, r_silence_limit;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        out_load;

    t_rx_phase   r_rx_phase, n_rx_phase;
    logic        r_drive_mode, n_drive_mode;
    logic [7:0]  r_setpoint, n_setpoint;
    logic [15:0] r_enc_total, n_enc_total;
    logic [15:0] r_enc_previous, n_enc_previous;
    logic [15:0] r_velocity, n_velocity;
    logic [7:0]  r_current, n_current;
    logic [7:0]  r_temperature, n_temperature;
    logic        r_adc_channel, n_adc_channel;
    logic [7:0]  r_drive_store, n_drive_store;
    logic [7:0]  r_silence_count, n_silence_count;
    logic [7:0]  r_host_volt, n_host_volt;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic        n_due, n_forced;
    logic        link_ev;

    assign out_load    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign link_ev     = (t_req'(r_in.req_type) == REQ_LINK);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed_hdr    <= CLOSED_HDR_RESET;
            r_direct_hdr    <= DIRECT_HDR_RESET;
            r_silence_limit <= SILENCE_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLOSED_HDR:    r_closed_hdr    <= i_cfg_data;
                CFG_DIRECT_HDR:    r_direct_hdr    <= i_cfg_data;
                CFG_SILENCE_LIMIT: r_silence_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // packet receiver next state
    always_comb begin
        n_rx_phase = r_rx_phase;
        if (link_ev) begin
            unique case (r_rx_phase)
                RX_HEADER: begin
                    if (r_in.link_byte == r_closed_hdr || r_in.link_byte == r_direct_hdr) begin
                        n_rx_phase = RX_SETPOINT;
                    end
                end
                RX_SETPOINT: n_rx_phase = RX_VOLTAGE;
                RX_VOLTAGE:  n_rx_phase = RX_DRIVE;
                RX_DRIVE:    n_rx_phase = RX_TAIL;
                default:     n_rx_phase = RX_HEADER;
            endcase
        end
    end

    // datapath and receiver outputs
    always_comb begin
        n_drive_mode    = r_drive_mode;
        n_setpoint      = r_setpoint;
        n_enc_total     = r_enc_total;
        n_enc_previous  = r_enc_previous;
        n_velocity      = r_velocity;
        n_current       = r_current;
        n_temperature   = r_temperature;
        n_adc_channel   = r_adc_channel;
        n_drive_store   = r_drive_store;
        n_silence_count = r_silence_count;
        n_host_volt     = r_host_volt;
        n_tx_byte       = r_tx_byte;
        n_due           = 1'b0;
        n_forced        = 1'b0;
        case (t_req'(r_in.req_type))
            REQ_LINK: begin
                unique case (r_rx_phase)
                    RX_HEADER: begin
                        n_tx_byte = r_velocity[9:2];
                        if (r_in.link_byte == r_closed_hdr) begin
                            n_drive_mode = 1'b0;
                        end else if (r_in.link_byte == r_direct_hdr) begin
                            n_drive_mode = 1'b1;
                        end
                    end
                    RX_SETPOINT: begin
                        n_setpoint      = r_in.link_byte;
                        n_silence_count = 8'd0;
                        n_tx_byte       = r_current;
                    end
                    RX_VOLTAGE: begin
                        n_host_volt = r_in.link_byte;
                        n_tx_byte   = r_temperature;
                    end
                    RX_DRIVE: n_tx_byte = r_drive_store;
                    default:  n_tx_byte = 8'd0;
                endcase
            end
            REQ_ENC: begin
                if (r_in.chan_a == r_in.chan_b) begin
                    n_enc_total = r_enc_total - 16'd1;
                end else begin
                    n_enc_total = r_enc_total + 16'd1;
                end
            end
            REQ_TICK: begin
                n_velocity     = r_enc_total - r_enc_previous;
                n_enc_previous = r_enc_total;
                n_due          = 1'b1;
                if (r_silence_count > r_silence_limit) begin
                    n_setpoint      = 8'd0;
                    n_silence_count = 8'd0;
                    n_forced        = 1'b1;
                end else begin
                    n_silence_count = r_silence_count + 8'd1;
                end
            end
            REQ_ADC: begin
                if (!r_adc_channel) begin
                    n_current = r_in.adc_value;
                end else begin
                    n_temperature = r_in.adc_value;
                end
                n_adc_channel = !r_adc_channel;
            end
            REQ_DRIVE: n_drive_store = r_in.applied_drive;
            default: ;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_rx_phase      <= RX_HEADER;
            r_drive_mode    <= 1'b0;
            r_setpoint      <= 8'd0;
            r_enc_total     <= 16'd0;
            r_enc_previous  <= 16'd0;
            r_velocity      <= 16'd0;
            r_current       <= 8'd0;
            r_temperature   <= 8'd0;
            r_adc_channel   <= 1'b0;
            r_drive_store   <= 8'd0;
            r_silence_count <= SILENCE_COUNT_RESET;
            r_host_volt     <= 8'd0;
            r_tx_byte       <= 8'd0;
        end else begin
            if (out_load) begin
                r_out_valid     <= 1'b1;
                r_rx_phase      <= n_rx_phase;
                r_drive_mode    <= n_drive_mode;
                r_setpoint      <= n_setpoint;
                r_enc_total     <= n_enc_total;
                r_enc_previous  <= n_enc_previous;
                r_velocity      <= n_velocity;
                r_current       <= n_current;
                r_temperature   <= n_temperature;
                r_adc_channel   <= n_adc_channel;
                r_drive_store   <= n_drive_store;
                r_silence_count <= n_silence_count;
                r_host_volt     <= n_host_volt;
                r_tx_byte       <= n_tx_byte;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.reply_byte   <= n_tx_byte;
            r_out.setpoint_now <= n_setpoint;
            r_out.mode_now     <= n_drive_mode;
            r_out.velocity_now <= n_velocity;
            r_out.update_due   <= n_due;
            r_out.timed_out    <= n_forced;
            r_out.host_voltage <= n_host_volt;
        end
    end

    a_timeout_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out) |-> o_out_data.update_due)
        else $error("timeout flagged without tick");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out) |-> (o_out_data.setpoint_now == 8'sd0))
        else $error("timeout left setpoint non-zero");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_phase_reset_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && link_ev && r_rx_phase == RX_TAIL) |=>
            (r_rx_phase == RX_HEADER && o_out_data.reply_byte == 8'd0))
        else $error("packet end not handled");

endmodule
